[rtl/fir_lat_pkg.sv]
// package: constants, register codes and helpers for the lattice filter
`timescale 1ns / 1ps
package fir_lat_pkg;

  localparam int MAX_ORDER_DEF   = 16;
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int COEF_BITS_DEF   = 16;
  localparam int STAGE_BITS_DEF  = 24;
  localparam int ORDER_W         = 5;
  localparam int COUNT_W         = 16;
  localparam int CFG_IDX_W       = 2;
  localparam int CFG_DATA_W      = 16;
  localparam int COEF_IDX_W      = 4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ORDER     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_LEN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SAVE_PT   = 2'd2;

  // request commands
  localparam logic CMD_LOAD_COEF = 1'b0;
  localparam logic CMD_FILTER    = 1'b1;

  // sequencer states
  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_LOAD   = 6'b000010,
    ST_MUL    = 6'b000100,
    ST_ADD    = 6'b001000,
    ST_SAVE   = 6'b010000,
    ST_OUT    = 6'b100000
  } fl_state_t;

endpackage

[rtl/fir_lat_if.sv]
// interfaces: request, result and configuration channels
`timescale 1ns / 1ps
interface fir_lat_in_if #(
  parameter int SAMPLE_BITS = 16,
  parameter int COEF_BITS   = 16
);
  logic                          valid;
  logic                          ready;
  logic                          command;
  logic [3:0]                    coef_index;
  logic signed [COEF_BITS-1:0]   coef_value;
  logic signed [SAMPLE_BITS-1:0] sample;
  modport source (output valid, command, coef_index, coef_value, sample, input ready);
  modport sink   (input valid, command, coef_index, coef_value, sample, output ready);
endinterface

interface fir_lat_out_if #(
  parameter int SAMPLE_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] filtered;
  logic                          saturated;
  modport source (output valid, filtered, saturated, input ready);
  modport sink   (input valid, filtered, saturated, output ready);
endinterface

interface fir_lat_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[rtl/fir_lat_ram.sv]
// generic single-port write, single-port read ram with registered read
`timescale 1ns / 1ps
module fir_lat_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

[rtl/fir_lattice_filter_core.sv]
// top level: fixed-point fir lattice filter with one shared bit-serial multiplier
`timescale 1ns / 1ps
//
// channel  dir  payload                                   handshake
// in       in   command, coef_index, coef_value, sample   in_valid / in_ready
// out      out  filtered, saturated                       out_valid / out_ready
// cfg      in   index, data                               cfg_valid / cfg_ready
//
// a coefficient request is taken in idle and gives no result. a sample runs,
// for each of the n stages (n the effective order), through a read state, two
// serial products on one shift-add unit, each followed by a sum state; then
// the output state, and back to idle, where the next request is taken, so a
// new request waits until the sample before it is through.
// reset (rst_n low, synchronous) clears control and the delay, snapshot and
// coefficient state through valid bits, and sets the configuration registers to
// their defaults. requests and config writes are taken only in idle; a result
// still waiting for out_ready stalls only the output state of the next sample.
module fir_lattice_filter_core
  import fir_lat_pkg::*;
#(
  parameter int MAX_ORDER   = MAX_ORDER_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int COEF_BITS   = COEF_BITS_DEF,
  parameter int STAGE_BITS  = STAGE_BITS_DEF
) (
  input logic               clk,
  input logic               rst_n,
  fir_lat_in_if.sink        in_ch,
  fir_lat_out_if.source     out_ch,
  fir_lat_cfg_if.sink       cfg_ch
);
  localparam int AW    = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
  localparam int SH    = COEF_BITS - 2;
  localparam int PW    = STAGE_BITS + COEF_BITS + 1;
  localparam int MCW   = $clog2(COEF_BITS + 1);
  localparam int SUMW  = STAGE_BITS + 2;

  // state
  fl_state_t state_r, state_nxt;

  // configuration registers
  logic [ORDER_W-1:0] order_r;
  logic [COUNT_W-1:0] blen_r, save_r;
  assign cfg_ch.ready = (state_r == ST_IDLE);
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      order_r <= ORDER_W'(16);
      blen_r  <= COUNT_W'(1);
      save_r  <= COUNT_W'(1);
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      case (cfg_ch.index)
        REG_ORDER:     order_r <= cfg_ch.data[ORDER_W-1:0];
        REG_BLOCK_LEN: blen_r  <= cfg_ch.data;
        REG_SAVE_PT:   save_r  <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  // effective order and block length
  logic [AW:0]        n_eff;
  logic [COUNT_W-1:0] blen_eff;
  always_comb begin
    if (order_r == '0) n_eff = (AW+1)'(1);
    else if (32'(order_r) > MAX_ORDER) n_eff = (AW+1)'(MAX_ORDER);
    else n_eff = (AW+1)'(order_r);
    blen_eff = (blen_r == '0) ? COUNT_W'(1) : blen_r;
  end

  logic [AW:0]  stage_r;
  logic [AW-1:0] sidx;
  assign sidx = stage_r[AW-1:0];
  logic [MAX_ORDER-1:0] dvalid_r, svalid_r, cvalid_r;
  logic [COUNT_W-1:0] count_r;
  logic reload_r, save_en_r;

  // memories: coefficients, working delays, snapshot
  logic coef_we, dly_we, snap_we;
  logic [AW-1:0] coef_wa, dly_wa, snap_wa, rd_a;
  logic [COEF_BITS-1:0]  coef_wd, coef_rd;
  logic [STAGE_BITS-1:0] dly_wd, dly_rd, snap_rd;
  fir_lat_ram #(.WIDTH(COEF_BITS), .DEPTH(MAX_ORDER)) u_coef (
    .clk, .we(coef_we), .waddr(coef_wa), .wdata(coef_wd), .raddr(rd_a), .rdata(coef_rd));
  fir_lat_ram #(.WIDTH(STAGE_BITS), .DEPTH(MAX_ORDER)) u_dly (
    .clk, .we(dly_we), .waddr(dly_wa), .wdata(dly_wd), .raddr(rd_a), .rdata(dly_rd));
  fir_lat_ram #(.WIDTH(STAGE_BITS), .DEPTH(MAX_ORDER)) u_snap (
    .clk, .we(snap_we), .waddr(snap_wa), .wdata(dly_wd), .raddr(rd_a), .rdata(snap_rd));

  // datapath registers
  logic signed [STAGE_BITS-1:0] fwd_r, carry_r, d_r, bwd_r;
  logic signed [COEF_BITS-1:0]  k_r;
  logic [MCW-1:0]  bit_r;
  logic            phase_r;        // 0: k*fwd, 1: k*d
  logic [PW-1:0]   acc_r;          // unsigned magnitude accumulator
  logic [STAGE_BITS-1:0] mcand_r;  // magnitude of stage value
  logic [COEF_BITS-1:0]  mplier_r; // magnitude of coefficient, shifts right
  logic            neg_r, sat_r;
  logic signed [SAMPLE_BITS-1:0] out_q_r;
  logic            out_sat_r;
  logic            out_v_r;

  // stage values come from snapshot at block start, else working delay
  logic signed [STAGE_BITS-1:0] d_cur;
  always_comb begin
    if (reload_r) d_cur = svalid_r[sidx] ? snap_rd : '0;
    else          d_cur = dvalid_r[sidx] ? dly_rd  : '0;
  end
  logic signed [COEF_BITS-1:0] k_cur;
  assign k_cur = cvalid_r[sidx] ? coef_rd : '0;

  // rounded product from the magnitude accumulator; any product beyond the
  // stage range saturates the sum
  logic [PW-1:0] mag_rnd;
  logic signed [PW:0] prod_s;
  assign mag_rnd = (acc_r + (PW'(1) << (SH-1))) >> SH;
  assign prod_s  = neg_r ? -$signed({1'b0, mag_rnd}) : $signed({1'b0, mag_rnd});

  // saturating stage sum
  logic signed [PW+1:0] sum_w;
  logic signed [STAGE_BITS-1:0] sum_clip;
  logic sum_ovf;
  localparam logic signed [PW+1:0] HI = (PW+2)'(2**(STAGE_BITS-1) - 1);
  localparam logic signed [PW+1:0] LO = -HI - 1;
  always_comb begin
    sum_w = (PW+2)'(phase_r ? fwd_r : d_r) + (PW+2)'(prod_s);
    sum_ovf = 1'b1;
    if (sum_w > HI) sum_clip = HI[STAGE_BITS-1:0];
    else if (sum_w < LO) sum_clip = LO[STAGE_BITS-1:0];
    else begin
      sum_clip = sum_w[STAGE_BITS-1:0];
      sum_ovf = 1'b0;
    end
  end

  // output clip
  localparam logic signed [STAGE_BITS-1:0] OHI = STAGE_BITS'(2**(SAMPLE_BITS-1) - 1);
  localparam logic signed [STAGE_BITS-1:0] OLO = -OHI - 1;

  logic out_free;
  assign out_free = !out_v_r || out_ch.ready;
  assign in_ch.ready = (state_r == ST_IDLE);
  assign out_ch.valid = out_v_r;
  assign out_ch.filtered = out_q_r;
  assign out_ch.saturated = out_sat_r;
  logic in_acc;
  assign in_acc = in_ch.valid && in_ch.ready;

  // read address is set ahead for the registered ram read: stage 0 in idle, the next stage in the second sum
  assign rd_a    = (state_r == ST_IDLE) ? '0 :
                   ((state_r == ST_ADD) && phase_r) ? AW'(sidx + 1'b1) : sidx;
  assign coef_we = in_acc && (in_ch.command == CMD_LOAD_COEF)
                   && (32'(in_ch.coef_index) < MAX_ORDER);
  assign coef_wa = AW'(in_ch.coef_index);
  assign coef_wd = in_ch.coef_value;
  assign dly_we  = (state_r == ST_ADD) && phase_r;
  assign dly_wa  = sidx;
  assign dly_wd  = carry_r;
  assign snap_we = dly_we && save_en_r;
  assign snap_wa = sidx;

  logic last_stage;
  assign last_stage = (stage_r + 1'b1) == n_eff;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_acc && in_ch.command == CMD_FILTER) state_nxt = ST_LOAD;
      ST_LOAD: state_nxt = ST_MUL;
      ST_MUL:  if (32'(bit_r) == COEF_BITS - 1) state_nxt = ST_ADD;
      ST_ADD:  begin
        if (!phase_r) state_nxt = ST_MUL;
        else if (last_stage) state_nxt = ST_OUT;
        else state_nxt = ST_LOAD;
      end
      ST_OUT:  if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // sequencer and datapath
  logic [COUNT_W-1:0] cnt_inc;
  assign cnt_inc = count_r + 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      dvalid_r <= '0;
      svalid_r <= '0;
      cvalid_r <= '0;
      count_r  <= '0;
      out_v_r  <= 1'b0;
      out_sat_r <= 1'b0;
      stage_r  <= '0;
      phase_r  <= 1'b0;
      reload_r <= 1'b0;
      save_en_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if ((state_r == ST_OUT) && out_free) out_v_r <= 1'b1;
      else if (out_v_r && out_ch.ready) out_v_r <= 1'b0;
      if (coef_we) cvalid_r[coef_wa] <= 1'b1;
      if (dly_we) dvalid_r[dly_wa] <= 1'b1;
      if (snap_we) svalid_r[snap_wa] <= 1'b1;
      case (state_r)
        ST_IDLE: if (in_acc && in_ch.command == CMD_FILTER) begin
          stage_r  <= '0;
          phase_r  <= 1'b0;
          fwd_r    <= STAGE_BITS'(in_ch.sample);
          carry_r  <= STAGE_BITS'(in_ch.sample);
          sat_r    <= 1'b0;
          reload_r <= (count_r == '0);
          save_en_r <= (save_r != '0) && (save_r <= blen_eff) && (cnt_inc == save_r);
        end
        ST_LOAD: begin
          d_r <= d_cur;
          k_r <= k_cur;
          acc_r <= '0;
          bit_r <= '0;
          mplier_r <= k_cur[COEF_BITS-1] ? -k_cur : k_cur;
          mcand_r <= fwd_r[STAGE_BITS-1] ? -fwd_r : fwd_r;
          neg_r <= k_cur[COEF_BITS-1] ^ fwd_r[STAGE_BITS-1];
        end
        ST_MUL: begin
          if (mplier_r[0]) acc_r <= acc_r + (PW'(mcand_r) << bit_r);
          mplier_r <= mplier_r >> 1;
          bit_r <= bit_r + 1'b1;
        end
        ST_ADD: begin
          if (!phase_r) begin
            bwd_r <= sum_clip;
            phase_r <= 1'b1;
            acc_r <= '0;
            bit_r <= '0;
            mplier_r <= k_r[COEF_BITS-1] ? -k_r : k_r;
            mcand_r <= d_r[STAGE_BITS-1] ? -d_r : d_r;
            neg_r <= k_r[COEF_BITS-1] ^ d_r[STAGE_BITS-1];
          end else begin
            fwd_r <= sum_clip;
            carry_r <= bwd_r;
            phase_r <= 1'b0;
            stage_r <= stage_r + 1'b1;
          end
          if (sum_ovf) sat_r <= 1'b1;
        end
        ST_OUT: if (out_free) begin
          if (fwd_r > OHI) begin
            out_q_r <= OHI[SAMPLE_BITS-1:0]; out_sat_r <= 1'b1;
          end else if (fwd_r < OLO) begin
            out_q_r <= OLO[SAMPLE_BITS-1:0]; out_sat_r <= 1'b1;
          end else begin
            out_q_r <= fwd_r[SAMPLE_BITS-1:0]; out_sat_r <= sat_r;
          end
          count_r <= (cnt_inc >= blen_eff || cnt_inc == '0) ? '0 : cnt_inc;
        end
        default: ;
      endcase
    end
  end
endmodule

[verif/fir_lattice_filter_core_tb.sv]
// testbench: fir lattice filter core checked against a fixed-point filter predictor
`timescale 1ns / 1ps
module fir_lattice_filter_core_tb
  import fir_lat_pkg::*;
();

  localparam int NSTG = MAX_ORDER_DEF;
  localparam int WD_LIMIT = 20000;

  typedef struct packed {
    logic signed [SAMPLE_BITS_DEF-1:0] filtered;
    logic                              saturated;
  } lat_result_t;

  // filter state mirror, expected result queue
  class lattice_scoreboard;
    logic signed [STAGE_BITS_DEF-1:0] delays [NSTG];
    logic signed [STAGE_BITS_DEF-1:0] snap [NSTG];
    logic signed [COEF_BITS_DEF-1:0]  coefs [NSTG];
    logic [COUNT_W-1:0]               count;
    logic [ORDER_W-1:0]               order;
    logic [COUNT_W-1:0]               blen;
    logic [COUNT_W-1:0]               save_pt;
    lat_result_t                      expected_q [$];

    function new();
      for (int i = 0; i < NSTG; i++) begin
        delays[i] = '0;
        snap[i] = '0;
        coefs[i] = '0;
      end
      count = '0;
      order = 5'd16;
      blen = 16'd1;
      save_pt = 16'd1;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_ORDER: order = data[ORDER_W-1:0];
        REG_BLOCK_LEN: blen = data;
        REG_SAVE_PT: save_pt = data;
        default: ;
      endcase
    endfunction

    // rounded (k * v) >> 14, ties away from zero
    function longint scaled_mul(longint k, longint v);
      bit neg;
      longint mag;
      neg = (k < 0) != (v < 0);
      mag = ((k < 0 ? -k : k) * (v < 0 ? -v : v) + (64'sd1 << (COEF_BITS_DEF - 3)))
            >>> (COEF_BITS_DEF - 2);
      if (mag > (64'sd1 <<< 62)) mag = 64'sd1 <<< 62;
      return neg ? -mag : mag;
    endfunction

    function longint clip(longint v, int bits, ref bit flag);
      longint hi;
      hi = (64'sd1 <<< (bits - 1)) - 1;
      if (v > hi) begin
        flag = 1'b1;
        return hi;
      end
      if (v < -hi - 1) begin
        flag = 1'b1;
        return -hi - 1;
      end
      return v;
    endfunction

    function void note_request(logic cmd, logic [3:0] idx, logic signed [15:0] cv,
                               logic signed [15:0] smp);
      int n;
      longint bl, f, c, b, d, k;
      bit flag;
      lat_result_t r;
      if (cmd == CMD_LOAD_COEF) begin
        coefs[idx] = cv;
        return;
      end
      n = (order == 0) ? 1 : ((order > NSTG) ? NSTG : int'(order));
      bl = (blen == 0) ? 1 : longint'(blen);
      flag = 1'b0;
      // block start reloads from the snapshot
      if (count == 0)
        for (int i = 0; i < n; i++) delays[i] = snap[i];
      f = smp;
      c = f;
      for (int i = 0; i < n; i++) begin
        d = delays[i];
        k = coefs[i];
        b = clip(d + scaled_mul(k, f), STAGE_BITS_DEF, flag);
        f = clip(f + scaled_mul(k, d), STAGE_BITS_DEF, flag);
        delays[i] = c[STAGE_BITS_DEF-1:0];
        c = b;
      end
      f = clip(f, SAMPLE_BITS_DEF, flag);
      if (save_pt != 0 && save_pt <= bl && longint'(count) + 1 == save_pt)
        for (int i = 0; i < n; i++) snap[i] = delays[i];
      count = count + 1'b1;
      if (count >= bl || count == 0) count = '0;
      r.filtered = f[SAMPLE_BITS_DEF-1:0];
      r.saturated = flag;
      expected_q.push_back(r);
    endfunction

    // empty string when the result matches
    function string check_result(logic signed [15:0] filtered, logic saturated);
      lat_result_t e;
      if (expected_q.size() == 0)
        return $sformatf("result %0d/%0b with none expected", filtered, saturated);
      e = expected_q.pop_front();
      if (filtered !== e.filtered || saturated !== e.saturated)
        return $sformatf("got %0d/%0b expected %0d/%0b", filtered, saturated,
                         e.filtered, e.saturated);
      return "";
    endfunction
  endclass

  logic clk;
  logic rst_n;
  int   errors;
  int   idle_cycles;
  int   in_idle_pct;
  int   out_stall_pct;
  lattice_scoreboard sb;

  fir_lat_in_if  in_ch ();
  fir_lat_out_if out_ch ();
  fir_lat_cfg_if cfg_ch ();

  fir_lattice_filter_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  task automatic report(string msg);
    $display("mismatch: %s", msg);
    errors++;
  endtask

  // request and config monitors feed the predictor
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready)
      sb.note_request(in_ch.command, in_ch.coef_index, in_ch.coef_value, in_ch.sample);
    if (rst_n && cfg_ch.valid && cfg_ch.ready)
      sb.set_reg(cfg_ch.index, cfg_ch.data);
  end

  // result checker
  always @(posedge clk) begin
    string msg;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      msg = sb.check_result(out_ch.filtered, out_ch.saturated);
      if (msg != "") report(msg);
    end
  end

  // receiver stalls
  always @(posedge clk)
    out_ch.ready <= ($urandom_range(99) >= out_stall_pct);

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready))
      idle_cycles <= 0;
    else if (idle_cycles >= WD_LIMIT) begin
      $display("fir_lattice_filter_core test failed");
      $finish;
    end else
      idle_cycles <= idle_cycles + 1;
  end

  task automatic send_req(logic cmd, logic [3:0] idx, logic signed [15:0] cv,
                          logic signed [15:0] smp);
    while ($urandom_range(99) < in_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.command <= cmd;
    in_ch.coef_index <= idx;
    in_ch.coef_value <= cv;
    in_ch.sample <= smp;
    forever begin
      @(posedge clk);
      if (in_ch.ready) break;
    end
  endtask

  // valid stays high across back-to-back writes, the caller drops it
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= data;
    forever begin
      @(posedge clk);
      if (cfg_ch.ready) break;
    end
  endtask

  // drain results, then let a trailing coefficient load finish
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic set_phase(int ord, int bl, int sp, int in_pct, int out_pct);
    wait_drained();
    write_reg(REG_ORDER, CFG_DATA_W'(ord));
    write_reg(REG_BLOCK_LEN, CFG_DATA_W'(bl));
    write_reg(REG_SAVE_PT, CFG_DATA_W'(sp));
    cfg_ch.valid <= 1'b0;
    in_idle_pct = in_pct;
    out_stall_pct = out_pct;
  endtask

  // mostly samples, some coefficient loads, coefficients often moderate
  task automatic random_reqs(int count);
    logic signed [15:0] cv;
    for (int i = 0; i < count; i++) begin
      cv = ($urandom_range(1) != 0) ? 16'($urandom) : 16'($urandom_range(16383) - 8192);
      send_req(($urandom_range(3) != 0) ? CMD_FILTER : CMD_LOAD_COEF,
               4'($urandom_range(15)), cv, 16'($urandom));
    end
  endtask

  initial begin
    errors = 0;
    idle_cycles = 0;
    in_idle_pct = 0;
    out_stall_pct = 0;
    sb = new();
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.command = CMD_LOAD_COEF;
    in_ch.coef_index = '0;
    in_ch.coef_value = '0;
    in_ch.sample = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_ORDER;
    cfg_ch.data = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset settings, extreme coefficients and samples
    send_req(CMD_FILTER, 4'd0, 16'sd0, 16'sd32767);
    send_req(CMD_LOAD_COEF, 4'd0, -16'sd32768, 16'sd0);
    send_req(CMD_LOAD_COEF, 4'd15, 16'sd32767, 16'sd0);
    send_req(CMD_LOAD_COEF, 4'd1, 16'sd16384, 16'sd0);
    send_req(CMD_LOAD_COEF, 4'd2, -16'sd16384, 16'sd0);
    send_req(CMD_FILTER, 4'd0, 16'sd0, -16'sd32768);
    send_req(CMD_FILTER, 4'd0, 16'sd0, 16'sd32767);
    send_req(CMD_FILTER, 4'd0, 16'sd0, 16'sd0);
    send_req(CMD_FILTER, 4'd0, 16'sd0, -16'sd1);
    send_req(CMD_FILTER, 4'd0, 16'sd0, 16'sd1);
    set_phase(16, 1, 0, 0, 0);
    send_req(CMD_LOAD_COEF, 4'd7, 16'sd32767, 16'sd0);
    send_req(CMD_FILTER, 4'd0, 16'sd0, -16'sd32768);
    send_req(CMD_FILTER, 4'd0, 16'sd0, 16'sd32767);
    send_req(CMD_LOAD_COEF, 4'd3, -16'sd1, 16'sd0);
    send_req(CMD_FILTER, 4'd0, 16'sd0, -16'sd32768);
    send_req(CMD_FILTER, 4'd0, 16'sd0, 16'sd32767);

    // random phases across settings and handshake pressure
    set_phase(3, 8, 3, 0, 0);
    random_reqs(275);
    set_phase(1, 5, 0, 53, 0);
    random_reqs(200);
    set_phase(5, 65535, 65535, 0, 53);
    random_reqs(150);
    set_phase(0, 0, 1, 24, 24);
    random_reqs(200);
    set_phase(31, 4, 9, 0, 0);
    random_reqs(100);
    set_phase(2, 2, 2, 53, 53);
    random_reqs(200);
    set_phase(16, 3, 2, 0, 0);
    random_reqs(100);
    set_phase(6, 7, 7, 24, 24);
    random_reqs(150);
    set_phase(17, 6, 6, 0, 0);
    random_reqs(40);

    wait_drained();
    repeat (20) @(posedge clk);
    if (errors == 0 && sb.expected_q.size() == 0)
      $display("fir_lattice_filter_core test passed");
    else
      $display("fir_lattice_filter_core test failed");
    $finish;
  end

endmodule
